FILE: rtl/core/trz_pkg.sv
// trz_pkg: shared types, codes and constants of the triangle rasterizer core
// used by every module under rtl/core; depends on nothing
package trz_pkg;

  // default store geometry
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // operation codes on in_tuser
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_DRAW  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_CCOLOR = 2'd2;
  localparam logic [1:0] CFG_CDEPTH = 2'd3;

  // configuration reset values
  localparam logic [8:0]         WIDTH_RST  = 9'd256;
  localparam logic [8:0]         HEIGHT_RST = 9'd256;
  localparam logic [23:0]        CCOLOR_RST = 24'd255;
  localparam logic signed [23:0] CDEPTH_RST = -24'sd100000;

  // divider geometry: numerator 2*diff*num (+ den except for the span step), denominator 2*den
  localparam int DIV_NW = 46;
  localparam int DIV_DW = 17;

  // classified command kind
  typedef enum logic [1:0] {
    K_CLEAR = 2'd0,
    K_DRAW  = 2'd1,
    K_READ  = 2'd2,
    K_NOP   = 2'd3
  } kind_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [23:0] z;
  } vtx_t;

  // command handed from front to back, vertices already ordered by y
  typedef struct packed {
    kind_t        kind;
    vtx_t         v0;
    vtx_t         v1;
    vtx_t         v2;
    logic [15:0]  total;
    logic [15:0]  h01;
    logic [15:0]  h12;
    logic [23:0]  color;
    logic [15:0]  rindex;
  } cmd_t;

  // frame settings as seen by the back end
  typedef struct packed {
    logic [8:0]         fw;
    logic [8:0]         fh;
    logic [23:0]        clear_color;
    logic signed [23:0] clear_depth;
  } cfg_t;

  typedef struct packed {
    logic [23:0]        read_color;
    logic signed [23:0] read_depth;
    logic [16:0]        pixels_written;
  } res_t;

endpackage

FILE: rtl/core/triangle_rasterizer_zbuffer_core.sv
// Triangle rasterizer with depth buffer: each input beat is a clear, a
// flat-shaded triangle draw or a pixel read (other codes are no-ops), and each
// gives exactly one result beat. A front stage decodes the beat and orders the
// vertices by y, then a two-entry command queue feeds the back end, which owns
// the color and depth stores. A clear sweeps the whole store, one entry a
// cycle. A draw walks the rows of the triangle: a row outside the frame is
// skipped; a row inside computes both edge points (x and z each), then the
// span depth start and step when the span is longer than one pixel, all
// through one shared iterative divider, then does a depth read-modify-write
// on the store port for each covered pixel. The stores hold nothing defined
// until the first clear. Config writes belong to idle periods only.
module triangle_rasterizer_zbuffer_core #(
  parameter int MAX_WIDTH  = trz_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = trz_pkg::MAX_HEIGHT_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // x0, y0, z0, x1, y1, z1, x2, y2, z2, tri_color, read_index
  input  logic [207:0] in_tdata,
  // func
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // read_color, read_depth, pixels_written, zero pad
  output logic [71:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_wdata
);

  logic [8:0]  width_r, height_r;
  logic [23:0] ccolor_r, cdepth_r;
  trz_pkg::cfg_t cfg;
  logic [8:0]  fw, fh;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= trz_pkg::WIDTH_RST;
      height_r <= trz_pkg::HEIGHT_RST;
      ccolor_r <= trz_pkg::CCOLOR_RST;
      cdepth_r <= trz_pkg::CDEPTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        trz_pkg::CFG_WIDTH:  width_r  <= cfg_wdata[8:0];
        trz_pkg::CFG_HEIGHT: height_r <= cfg_wdata[8:0];
        trz_pkg::CFG_CCOLOR: ccolor_r <= cfg_wdata;
        trz_pkg::CFG_CDEPTH: cdepth_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // frame size saturated to 1..max
  always_comb begin
    fw = width_r;
    if (width_r == 9'd0) begin
      fw = 9'd1;
    end else if (32'(width_r) > MAX_WIDTH) begin
      fw = 9'(MAX_WIDTH);
    end
    fh = height_r;
    if (height_r == 9'd0) begin
      fh = 9'd1;
    end else if (32'(height_r) > MAX_HEIGHT) begin
      fh = 9'(MAX_HEIGHT);
    end
  end

  assign cfg = '{fw: fw, fh: fh, clear_color: ccolor_r, clear_depth: cdepth_r};

  trz_pkg::cmd_t q_in_cmd, q_out_cmd;
  logic          q_push, q_full, q_pop, q_valid;
  trz_pkg::res_t res;

  trz_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in_cmd)
  );

  trz_cmdq #(.DEPTH(trz_pkg::QUEUE_DEPTH)) u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_in_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (q_out_cmd),
    .not_empty (q_valid)
  );

  trz_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (q_out_cmd),
    .cmd_valid  (q_valid),
    .cmd_pop    (q_pop),
    .cfg        (cfg),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  // result beat packing
  assign out_tdata = {7'b0, res.pixels_written, res.read_depth, res.read_color};

endmodule

FILE: rtl/core/trz_front.sv
// trz_front: accepts input beats, decodes the operation and orders vertices by y
// depends on trz_pkg
module trz_front (
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [207:0]        in_tdata,
  input  logic [1:0]          in_tuser,
  input  logic                q_full,
  output logic                q_push,
  output trz_pkg::cmd_t       q_cmd
);

  trz_pkg::vtx_t v0, v1, v2;
  trz_pkg::vtx_t a, b, c, t;
  logic signed [16:0] d_total, d_h01, d_h12;
  logic degen;

  // unpack vertices
  assign v0 = '{x: in_tdata[15:0],    y: in_tdata[31:16],   z: in_tdata[55:32]};
  assign v1 = '{x: in_tdata[71:56],   y: in_tdata[87:72],   z: in_tdata[111:88]};
  assign v2 = '{x: in_tdata[127:112], y: in_tdata[143:128], z: in_tdata[167:144]};

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // three compare-swaps on y
  always_comb begin
    a = v0;
    b = v1;
    c = v2;
    t = v0;
    if (a.y > b.y) begin
      t = a; a = b; b = t;
    end
    if (a.y > c.y) begin
      t = a; a = c; c = t;
    end
    if (b.y > c.y) begin
      t = b; b = c; c = t;
    end
  end

  assign degen   = (v0.y == v1.y) && (v0.y == v2.y);
  assign d_total = {c.y[15], c.y} - {a.y[15], a.y};
  assign d_h01   = {b.y[15], b.y} - {a.y[15], a.y};
  assign d_h12   = {c.y[15], c.y} - {b.y[15], b.y};

  // classify
  always_comb begin
    q_cmd.v0     = a;
    q_cmd.v1     = b;
    q_cmd.v2     = c;
    q_cmd.total  = d_total[15:0];
    q_cmd.h01    = d_h01[15:0];
    q_cmd.h12    = d_h12[15:0];
    q_cmd.color  = in_tdata[191:168];
    q_cmd.rindex = in_tdata[207:192];
    case (in_tuser)
      trz_pkg::FUNC_CLEAR: q_cmd.kind = trz_pkg::K_CLEAR;
      trz_pkg::FUNC_DRAW:  q_cmd.kind = degen ? trz_pkg::K_NOP : trz_pkg::K_DRAW;
      trz_pkg::FUNC_READ:  q_cmd.kind = trz_pkg::K_READ;
      default:             q_cmd.kind = trz_pkg::K_NOP;
    endcase
  end

endmodule

FILE: rtl/core/trz_cmdq.sv
// trz_cmdq: short command queue between front and back
// depends on trz_pkg
module trz_cmdq #(
  parameter int DEPTH = trz_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  trz_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output trz_pkg::cmd_t pop_cmd,
  output logic          not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  trz_pkg::cmd_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_cmd   = slot_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/core/trz_div.sv
// trz_div: iterative signed floor divider, one quotient bit per cycle
// depends on trz_pkg for default widths
module trz_div #(
  parameter int NW = trz_pkg::DIV_NW,
  parameter int DW = trz_pkg::DIV_DW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] numer,
  input  logic [DW-1:0]        denom,
  output logic                 done,
  output logic signed [NW-1:0] quot,
  output logic [DW-1:0]        rem
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r, fix_r, done_r, neg_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] dvd_r, quo_r;
  logic [DW-1:0] rem_r, d_r;
  logic [DW:0]   trial, trial_sub;
  logic          ge;

  assign trial     = {rem_r, dvd_r[NW-1]};
  assign trial_sub = trial - {1'b0, d_r};
  assign ge        = (trial >= {1'b0, d_r});

  // sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          fix_r  <= 1'b1;
        end
      end else if (fix_r) begin
        fix_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // magnitude division, then sign fix for floor rounding
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= numer[NW-1];
      dvd_r <= numer[NW-1] ? -numer : numer;
      rem_r <= '0;
      quo_r <= '0;
      d_r   <= denom;
    end else if (busy_r) begin
      rem_r <= ge ? trial_sub[DW-1:0] : trial[DW-1:0];
      dvd_r <= {dvd_r[NW-2:0], 1'b0};
      quo_r <= {quo_r[NW-2:0], ge};
    end else if (fix_r && neg_r) begin
      if (rem_r != '0) begin
        quo_r <= ~quo_r;
        rem_r <= d_r - rem_r;
      end else begin
        quo_r <= -quo_r;
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (!busy_r && !fix_r))
    else $error("divider restarted while working");

endmodule

FILE: rtl/core/trz_back.sv
// trz_back: executes clear, draw and read commands against the color and depth stores
// depends on trz_pkg and trz_div
module trz_back #(
  parameter int MAX_WIDTH  = trz_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = trz_pkg::MAX_HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  trz_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_pop,
  input  trz_pkg::cfg_t cfg,
  output logic          out_tvalid,
  input  logic          out_tready,
  output trz_pkg::res_t out_res
);

  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int NW = trz_pkg::DIV_NW;
  localparam int DW = trz_pkg::DIV_DW;

  localparam logic [2:0] OP_AX = 3'd0;
  localparam logic [2:0] OP_AZ = 3'd1;
  localparam logic [2:0] OP_BX = 3'd2;
  localparam logic [2:0] OP_BZ = 3'd3;
  localparam logic [2:0] OP_Q0 = 3'd4;
  localparam logic [2:0] OP_QS = 3'd5;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_CLR    = 14'b00000000000010,
    S_RD     = 14'b00000000000100,
    S_RDW    = 14'b00000000001000,
    S_ROW    = 14'b00000000010000,
    S_MUL    = 14'b00000000100000,
    S_DST    = 14'b00000001000000,
    S_DIV    = 14'b00000010000000,
    S_SWAP   = 14'b00000100000000,
    S_SPAN   = 14'b00001000000000,
    S_PIXRD  = 14'b00010000000000,
    S_PIXCMP = 14'b00100000000000,
    S_OUT    = 14'b01000000000000,
    S_NEXT   = 14'b10000000000000
  } st_t;

  st_t st_r;

  trz_pkg::cmd_t      cmd_r;
  logic [15:0]        i_r, j_r, jlo_r, jhi_r, cx_r;
  logic [2:0]         op_r;
  logic signed [15:0] ax_r, bx_r;
  logic signed [23:0] az_r, bz_r;
  logic signed [24:0] cz_r;
  logic [17:0]        row_base_r;
  logic [16:0]        d_r, r_r, rs_r;
  logic signed [25:0] q_r, qs_r;
  logic signed [42:0] prod_r;
  logic [16:0]        count_r;
  logic [23:0]        rc_r, rd_r;
  logic [AW-1:0]      clr_addr_r, pix_addr_r;
  logic [23:0]        color_rd_r, depth_rd_r;
  logic               out_valid_r;
  trz_pkg::res_t      out_res_r;

  logic [23:0] color_mem [STORE_SIZE];
  logic [23:0] depth_mem [STORE_SIZE];

  // operand selection for the shared interpolation divider
  logic               second;
  logic signed [25:0] op_base, op_diff;
  logic [15:0]        op_num, op_den;
  logic               op_add;

  always_comb begin
    second  = (i_r > cmd_r.h01) || (cmd_r.h01 == 16'd0);
    op_base = '0;
    op_diff = '0;
    op_num  = '0;
    op_den  = '0;
    op_add  = 1'b1;
    case (op_r)
      OP_AX: begin
        op_base = 26'(cmd_r.v0.x);
        op_diff = 26'(cmd_r.v2.x) - 26'(cmd_r.v0.x);
        op_num  = i_r;
        op_den  = cmd_r.total;
      end
      OP_AZ: begin
        op_base = 26'(cmd_r.v0.z);
        op_diff = 26'(cmd_r.v2.z) - 26'(cmd_r.v0.z);
        op_num  = i_r;
        op_den  = cmd_r.total;
      end
      OP_BX: begin
        if (second) begin
          op_base = 26'(cmd_r.v1.x);
          op_diff = 26'(cmd_r.v2.x) - 26'(cmd_r.v1.x);
          op_num  = i_r - cmd_r.h01;
          op_den  = cmd_r.h12;
        end else begin
          op_base = 26'(cmd_r.v0.x);
          op_diff = 26'(cmd_r.v1.x) - 26'(cmd_r.v0.x);
          op_num  = i_r;
          op_den  = cmd_r.h01;
        end
      end
      OP_BZ: begin
        if (second) begin
          op_base = 26'(cmd_r.v1.z);
          op_diff = 26'(cmd_r.v2.z) - 26'(cmd_r.v1.z);
          op_num  = i_r - cmd_r.h01;
          op_den  = cmd_r.h12;
        end else begin
          op_base = 26'(cmd_r.v0.z);
          op_diff = 26'(cmd_r.v1.z) - 26'(cmd_r.v0.z);
          op_num  = i_r;
          op_den  = cmd_r.h01;
        end
      end
      OP_Q0: begin
        op_diff = 26'(cz_r);
        op_num  = jlo_r;
        op_den  = cx_r;
      end
      OP_QS: begin
        op_diff = 26'(cz_r);
        op_num  = 16'd1;
        op_den  = cx_r;
        op_add  = 1'b0;
      end
      default: begin
        op_add = 1'b0;
      end
    endcase
  end

  // divider hookup
  logic                 div_start, div_done;
  logic signed [NW-1:0] div_numer, div_quot;
  logic [DW-1:0]        div_rem;
  logic signed [25:0]   op_sum;

  assign div_start = (st_r == S_DST);
  assign div_numer = {{2{prod_r[42]}}, prod_r, 1'b0} + (op_add ? NW'(op_den) : '0);
  assign op_sum    = op_base + div_quot[25:0];

  trz_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (div_numer),
    .denom ({op_den, 1'b0}),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // row and span geometry
  logic signed [16:0] row17;
  logic               row_in;
  logic               last_row;
  logic               do_swap;
  logic signed [16:0] cx17;
  logic signed [24:0] cz25;
  logic signed [17:0] jlo18, lim18, jhi18;
  logic               span_empty;

  assign row17    = {cmd_r.v0.y[15], cmd_r.v0.y} + $signed({1'b0, i_r});
  assign row_in   = !row17[16] && (row17[15:0] < {7'b0, cfg.fh});
  assign last_row = (i_r == cmd_r.total - 16'd1);
  assign do_swap  = (ax_r > bx_r);

  assign cx17  = {bx_r[15], bx_r} - {ax_r[15], ax_r};
  assign cz25  = {bz_r[23], bz_r} - {az_r[23], az_r};
  assign jlo18 = ax_r[15] ? -{{2{ax_r[15]}}, ax_r} : 18'sd0;
  assign lim18 = $signed({9'b0, cfg.fw}) - 18'sd1 - {{2{ax_r[15]}}, ax_r};
  assign jhi18 = ($signed({2'b0, cx17[15:0]}) < lim18) ? $signed({2'b0, cx17[15:0]}) : lim18;
  assign span_empty = (jhi18 < jlo18);

  // pixel addressing and depth test
  logic [16:0]        px17;
  logic [31:0]        pix_idx32, rd_idx32;
  logic [17:0]        area18;
  logic               read_in;
  logic signed [23:0] zcur;
  logic               pass;
  logic [17:0]        racc;
  logic               rwrap;

  assign px17      = {ax_r[15], ax_r} + {1'b0, j_r};
  assign pix_idx32 = 32'(row_base_r) + 32'(px17[8:0]);
  assign rd_idx32  = 32'(cmd_r.rindex);
  assign area18    = cfg.fw * cfg.fh;
  assign read_in   = ({2'b0, cmd_r.rindex} < area18);
  assign zcur      = az_r + q_r[23:0];
  assign pass      = ($signed(depth_rd_r) < zcur);
  assign racc      = {1'b0, r_r} + {1'b0, rs_r};
  assign rwrap     = (racc >= {1'b0, d_r});

  // store ports
  logic          mem_we, mem_re;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [23:0]   wr_color, wr_depth;

  assign mem_we   = (st_r == S_CLR) || ((st_r == S_PIXCMP) && pass);
  assign wr_addr  = (st_r == S_CLR) ? clr_addr_r : pix_addr_r;
  assign wr_color = (st_r == S_CLR) ? cfg.clear_color : cmd_r.color;
  assign wr_depth = (st_r == S_CLR) ? cfg.clear_depth : zcur;
  assign mem_re   = (st_r == S_RD) || (st_r == S_PIXRD);
  assign rd_addr  = (st_r == S_RD) ? rd_idx32[AW-1:0] : pix_idx32[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      color_mem[wr_addr] <= wr_color;
    end
    if (mem_re) begin
      color_rd_r <= color_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      depth_mem[wr_addr] <= wr_depth;
    end
    if (mem_re) begin
      depth_rd_r <= depth_mem[rd_addr];
    end
  end

  assign cmd_pop = (st_r == S_IDLE) && cmd_valid;

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if ((st_r == S_OUT) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.kind)
              trz_pkg::K_CLEAR: st_r <= S_CLR;
              trz_pkg::K_DRAW:  st_r <= S_ROW;
              trz_pkg::K_READ:  st_r <= S_RD;
              default:          st_r <= S_OUT;
            endcase
          end
        end
        S_CLR: begin
          if (clr_addr_r == AW'(STORE_SIZE - 1)) st_r <= S_OUT;
        end
        S_RD:  st_r <= S_RDW;
        S_RDW: st_r <= S_OUT;
        S_ROW: st_r <= row_in ? S_MUL : S_NEXT;
        S_MUL: st_r <= S_DST;
        S_DST: st_r <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            case (op_r)
              OP_BZ:   st_r <= S_SWAP;
              OP_QS:   st_r <= S_PIXRD;
              default: st_r <= S_MUL;
            endcase
          end
        end
        S_SWAP: st_r <= S_SPAN;
        S_SPAN: begin
          if (span_empty) begin
            st_r <= S_NEXT;
          end else if (cx17 == 17'sd0) begin
            st_r <= S_PIXRD;
          end else begin
            st_r <= S_MUL;
          end
        end
        S_PIXRD:  st_r <= S_PIXCMP;
        S_PIXCMP: st_r <= (j_r == jhi_r) ? S_NEXT : S_PIXRD;
        S_NEXT:   st_r <= last_row ? S_OUT : S_ROW;
        S_OUT: begin
          if (!out_valid_r || out_tready) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        cmd_r      <= cmd;
        i_r        <= '0;
        count_r    <= '0;
        rc_r       <= '0;
        rd_r       <= '0;
        clr_addr_r <= '0;
      end
      S_CLR: clr_addr_r <= clr_addr_r + 1'b1;
      S_RDW: begin
        if (read_in) begin
          rc_r <= color_rd_r;
          rd_r <= depth_rd_r;
        end
      end
      S_ROW: begin
        row_base_r <= row17[8:0] * cfg.fw;
        op_r       <= OP_AX;
      end
      S_MUL: prod_r <= op_diff * $signed({1'b0, op_num});
      S_DIV: begin
        if (div_done) begin
          op_r <= op_r + 3'd1;
          case (op_r)
            OP_AX: ax_r <= op_sum[15:0];
            OP_AZ: az_r <= op_sum[23:0];
            OP_BX: bx_r <= op_sum[15:0];
            OP_BZ: bz_r <= op_sum[23:0];
            OP_Q0: begin
              q_r <= div_quot[25:0];
              r_r <= div_rem;
            end
            OP_QS: begin
              qs_r <= div_quot[25:0];
              rs_r <= div_rem;
              j_r  <= jlo_r;
            end
            default: ;
          endcase
        end
      end
      S_SWAP: begin
        if (do_swap) begin
          ax_r <= bx_r;
          bx_r <= ax_r;
          az_r <= bz_r;
          bz_r <= az_r;
        end
      end
      S_SPAN: begin
        cx_r  <= cx17[15:0];
        cz_r  <= cz25;
        jlo_r <= jlo18[15:0];
        jhi_r <= jhi18[15:0];
        d_r   <= {cx17[15:0], 1'b0};
        op_r  <= OP_Q0;
        // zero-length span sits on its end point
        q_r   <= 26'(cz25);
        qs_r  <= '0;
        r_r   <= '0;
        rs_r  <= '0;
        j_r   <= jlo18[15:0];
      end
      S_PIXRD: pix_addr_r <= pix_idx32[AW-1:0];
      S_PIXCMP: begin
        if (pass) count_r <= count_r + 17'd1;
        j_r <= j_r + 16'd1;
        if (rwrap) begin
          r_r <= 17'(racc - {1'b0, d_r});
          q_r <= q_r + qs_r + 26'sd1;
        end else begin
          r_r <= racc[16:0];
          q_r <= q_r + qs_r;
        end
      end
      S_NEXT: i_r <= i_r + 16'd1;
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_res_r.read_color     <= rc_r;
          out_res_r.read_depth     <= rd_r;
          out_res_r.pixels_written <= count_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_res    = out_res_r;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == S_PIXRD) && (cx_r != 16'd0)) |-> (r_r < d_r))
    else $error("span remainder out of range");

  a_span_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_PIXRD) |-> (j_r <= jhi_r))
    else $error("pixel walk past span end");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == S_DIV))
    else $error("divider result arrived outside wait state");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == S_OUT))
    else $error("result raised without a finished command");

endmodule
